// ===== rtl/mssfl_pkg.sv =====
package mssfl_pkg;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [31:0] MOST_NEG = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_hold;
    } t_dp_stat;

endpackage

// ===== rtl/mssfl_if.sv =====
interface mssfl_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [1:0]         stack_id;
    logic signed [31:0] push_value;

    modport source (output valid, output action, output stack_id, output push_value,
                    input ready);
    modport sink   (input valid, input action, input stack_id, input push_value,
                    output ready);
endinterface

interface mssfl_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] pop_value;
    logic               store_full;
    logic               stack_empty;

    modport source (output valid, output status, output pop_value, output store_full,
                    output stack_empty, input ready);
    modport sink   (input valid, input status, input pop_value, input store_full,
                    input stack_empty, output ready);
endinterface

// ===== rtl/multi_stack_shared_free_list_top.sv =====
// A request is handled in S_IDLE and then S_EXEC: the accepting edge reads the addressed slot's
// link and data from the slot store, and the S_EXEC edge updates the lists and loads the result register.
// No new request is taken until S_EXEC is done; a result held by the sink stalls S_EXEC.
// Reset is synchronous and active low: every stack is empty and the free chain starts at slot 0.
// A fill count stands in for the initial free chain, so no clearing pass follows reset.
module multi_stack_shared_free_list_top #(
    parameter int DEPTH  = 16,
    parameter int STACKS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mssfl_in_if.sink     i_req,
    mssfl_out_if.source  o_rsp
);
    import mssfl_pkg::*;

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    mssfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (w_stat),
        .o_in_ready (i_req.ready),
        .o_cmd      (w_cmd)
    );

    mssfl_dp #(
        .DEPTH  (DEPTH),
        .STACKS (STACKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_action      (i_req.action),
        .i_stack_id    (i_req.stack_id),
        .i_push_value  (i_req.push_value),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_status      (o_rsp.status),
        .o_pop_value   (o_rsp.pop_value),
        .o_store_full  (o_rsp.store_full),
        .o_stack_empty (o_rsp.stack_empty)
    );

endmodule

// ===== rtl/mssfl_ctrl.sv =====
module mssfl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  mssfl_pkg::t_dp_stat  i_stat,
    output logic                 o_in_ready,
    output mssfl_pkg::t_ctrl_cmd o_cmd
);
    import mssfl_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.load = o_in_ready && i_in_valid;
        o_cmd.exec = (r_state == S_EXEC) && !i_stat.out_hold;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.exec) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/mssfl_dp.sv =====
module mssfl_dp #(
    parameter int DEPTH  = 16,
    parameter int STACKS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mssfl_pkg::t_ctrl_cmd i_cmd,
    output mssfl_pkg::t_dp_stat  o_stat,
    input  logic                 i_action,
    input  logic [1:0]           i_stack_id,
    input  logic signed [31:0]   i_push_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic signed [31:0]   o_pop_value,
    output logic                 o_store_full,
    output logic                 o_stack_empty
);
    import mssfl_pkg::*;

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
    localparam logic [PW-1:0] NONE = PW'(DEPTH);

    logic [31:0]   r_data_mem [DEPTH];
    logic [PW-1:0] r_link_mem [DEPTH];

    logic [PW-1:0] r_stack_top [STACKS];
    logic [PW-1:0] r_free_head;
    logic [PW-1:0] r_fill;
    logic          r_out_valid;

    logic          r_action;
    logic          r_sid_ok;
    logic [SW-1:0] r_idx;
    logic [31:0]   r_value;
    logic [PW-1:0] r_slot;
    logic          r_fresh;
    logic [PW-1:0] r_link_rd;
    logic [31:0]   r_data_rd;

    logic [1:0]    r_status;
    logic [31:0]   r_pop_value;
    logic          r_store_full;
    logic          r_stack_empty;

    logic          w_sid_ok;
    logic [SW-1:0] w_idx;
    logic [PW-1:0] w_rd_slot;
    logic          w_rd_en;
    logic          w_slot_none;
    logic [PW-1:0] w_link;
    logic [PW-1:0] w_top;
    logic          w_push_ok;
    logic          w_pop_ok;
    t_status       w_status;
    logic [31:0]   w_pop_value;
    logic          w_full;
    logic          w_empty;

    always_comb begin
        w_sid_ok  = (32'(i_stack_id) < STACKS);
        w_idx     = w_sid_ok ? SW'(i_stack_id) : '0;
        w_rd_slot = (i_action == ACT_PUSH) ? r_free_head : r_stack_top[w_idx];
        w_rd_en   = i_cmd.load && (w_rd_slot != NONE);
    end

    always_comb begin
        w_slot_none = (r_slot == NONE);
        w_link      = r_fresh ? (r_slot + PW'(1)) : r_link_rd;
        w_top       = r_stack_top[r_idx];
        w_push_ok   = i_cmd.exec && r_sid_ok && (r_action == ACT_PUSH) && !w_slot_none;
        w_pop_ok    = i_cmd.exec && r_sid_ok && (r_action == ACT_POP) && !w_slot_none;

        w_status    = ST_DONE;
        w_pop_value = '0;
        w_full      = (r_free_head == NONE);
        w_empty     = 1'b1;
        if (!r_sid_ok || w_slot_none) begin
            if (r_action == ACT_PUSH) begin
                w_status = ST_OVERFLOW;
            end else begin
                w_status    = ST_UNDERFLOW;
                w_pop_value = MOST_NEG;
            end
            if (r_sid_ok) begin
                w_empty = (w_top == NONE);
            end
        end else if (r_action == ACT_PUSH) begin
            w_full  = (w_link == NONE);
            w_empty = 1'b0;
        end else begin
            w_pop_value = r_data_rd;
            w_full      = 1'b0;
            w_empty     = (w_link == NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_link_mem[r_slot[AW-1:0]] <= w_top;
            r_data_mem[r_slot[AW-1:0]] <= r_value;
        end else if (w_pop_ok) begin
            r_link_mem[r_slot[AW-1:0]] <= r_free_head;
        end
        if (w_rd_en) begin
            r_link_rd <= r_link_mem[w_rd_slot[AW-1:0]];
            r_data_rd <= r_data_mem[w_rd_slot[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_sid_ok <= w_sid_ok;
            r_idx    <= w_idx;
            r_value  <= i_push_value;
            r_slot   <= w_rd_slot;
            r_fresh  <= (w_rd_slot >= r_fill);
        end
        if (i_cmd.exec) begin
            r_status      <= w_status;
            r_pop_value   <= w_pop_value;
            r_store_full  <= w_full;
            r_stack_empty <= w_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < STACKS; s++) begin
                r_stack_top[s] <= NONE;
            end
        end else begin
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_push_ok) begin
                r_free_head        <= w_link;
                r_stack_top[r_idx] <= r_slot;
                if (r_fresh) begin
                    r_fill <= r_slot + PW'(1);
                end
            end else if (w_pop_ok) begin
                r_stack_top[r_idx] <= w_link;
                r_free_head        <= r_slot;
            end
        end
    end

    assign o_stat.out_hold = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_pop_value     = r_pop_value;
    assign o_store_full    = r_store_full;
    assign o_stack_empty   = r_stack_empty;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

    import mssfl_pkg::*;

    localparam int DEPTH      = 16;
    localparam int STACKS     = 4;
    localparam logic [4:0] NIL = 5'(DEPTH);
    localparam int N_RANDOM   = 1275;
    localparam int QUIET_TAIL = 150;
    localparam int CYCLE_CAP  = 400000;

    typedef struct packed {
        logic               action;
        logic [1:0]         stack_id;
        logic signed [31:0] push_value;
        logic               drain_first;
    } t_stack_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] pop_value;
        logic               store_full;
        logic               stack_empty;
    } t_stack_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mssfl_in_if  req_if ();
    mssfl_out_if rsp_if ();

    multi_stack_shared_free_list_top #(
        .DEPTH  (DEPTH),
        .STACKS (STACKS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the shared store, the stack heads and the free chain.
    logic [31:0] slot_word [DEPTH];
    logic [4:0]  slot_next [DEPTH];
    logic [4:0]  stack_head [STACKS];
    logic [4:0]  free_head;

    t_stack_req pending [$];
    t_stack_rsp expected_rsp [$];
    t_stack_req cur_req;

    int n_total;
    int n_acc;
    int n_done;
    int n_got;
    int n_errors;
    int gap_left;
    int stall_left;
    int hold_left;
    int cycles;

    function automatic t_stack_rsp apply_stack_op(t_stack_req r);
        t_stack_rsp o;
        logic [4:0] slot;
        o.status      = ST_DONE;
        o.pop_value   = '0;
        o.stack_empty = 1'b1;
        if (int'(r.stack_id) >= STACKS) begin
            if (r.action == ACT_PUSH) begin
                o.status = ST_OVERFLOW;
            end else begin
                o.status    = ST_UNDERFLOW;
                o.pop_value = MOST_NEG;
            end
        end else if (r.action == ACT_PUSH) begin
            slot = free_head;
            if (slot == NIL) begin
                o.status = ST_OVERFLOW;
            end else begin
                free_head              = slot_next[slot];
                slot_next[slot]        = stack_head[r.stack_id];
                stack_head[r.stack_id] = slot;
                slot_word[slot]        = r.push_value;
            end
        end else begin
            slot = stack_head[r.stack_id];
            if (slot == NIL) begin
                o.status    = ST_UNDERFLOW;
                o.pop_value = MOST_NEG;
            end else begin
                stack_head[r.stack_id] = slot_next[slot];
                slot_next[slot]        = free_head;
                free_head              = slot;
                o.pop_value            = slot_word[slot];
            end
        end
        if (int'(r.stack_id) < STACKS) begin
            o.stack_empty = (stack_head[r.stack_id] == NIL);
        end
        o.store_full = (free_head == NIL);
        return o;
    endfunction

    task automatic queue_op(input logic act, input logic [1:0] sid,
                            input logic signed [31:0] val, input logic drain);
        t_stack_req r;
        r.action      = act;
        r.stack_id    = sid;
        r.push_value  = val;
        r.drain_first = drain;
        pending.push_back(r);
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_rsp.push_back(apply_stack_op(cur_req));
                n_acc++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (pending.size() > 0 &&
                             (!pending[0].drain_first || n_done == n_acc)) begin
                    cur_req = pending.pop_front();
                    req_if.valid      <= 1'b1;
                    req_if.action     <= cur_req.action;
                    req_if.stack_id   <= cur_req.stack_id;
                    req_if.push_value <= cur_req.push_value;
                    if (pending.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
                        gap_left = $urandom_range(1, 3);
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin
        t_stack_rsp want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_got++;
                n_done <= n_got;
                if (expected_rsp.size() == 0) begin
                    $display("%0t: result with no request outstanding, status %0d",
                             $time, rsp_if.status);
                    n_errors++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_if.status);
                        n_errors++;
                    end
                    if (rsp_if.pop_value !== want.pop_value) begin
                        $display("%0t: pop_value expected %0d actual %0d",
                                 $time, want.pop_value, rsp_if.pop_value);
                        n_errors++;
                    end
                    if (rsp_if.store_full !== want.store_full) begin
                        $display("%0t: store_full expected %0b actual %0b",
                                 $time, want.store_full, rsp_if.store_full);
                        n_errors++;
                    end
                    if (rsp_if.stack_empty !== want.stack_empty) begin
                        $display("%0t: stack_empty expected %0b actual %0b",
                                 $time, want.stack_empty, rsp_if.stack_empty);
                        n_errors++;
                    end
                end
                if (n_got == 300 || n_got == 900) begin
                    hold_left = 60;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (n_got < n_total - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int push_bias;
        logic act;
        logic signed [31:0] val;

        req_if.valid      = 1'b0;
        req_if.action     = ACT_PUSH;
        req_if.stack_id   = '0;
        req_if.push_value = '0;
        rsp_if.ready      = 1'b0;
        n_acc = 0;
        n_done = 0;
        n_got = 0;
        n_errors = 0;
        cycles = 0;

        for (int i = 0; i < DEPTH; i++) begin
            slot_word[i] = '0;
            slot_next[i] = 5'(i + 1);
        end
        for (int s = 0; s < STACKS; s++) begin
            stack_head[s] = NIL;
        end
        free_head = '0;

        // Extreme words on every stack, popped back, then a pop of an empty stack.
        queue_op(ACT_PUSH, 2'd0, 32'sh7FFF_FFFF, 1'b0);
        queue_op(ACT_PUSH, 2'd1, MOST_NEG, 1'b0);
        queue_op(ACT_PUSH, 2'd2, 32'sd0, 1'b0);
        queue_op(ACT_PUSH, 2'd3, -32'sd1, 1'b0);
        for (int s = 3; s >= 0; s--) begin
            queue_op(ACT_POP, 2'(s), 32'sd0, 1'b0);
        end
        queue_op(ACT_POP, 2'd2, -32'sd1, 1'b0);
        // Fill the whole store across all stacks, then push once more to overflow.
        for (int i = 0; i < DEPTH; i++) begin
            queue_op(ACT_PUSH, 2'(i % STACKS), 32'($urandom), 1'b0);
        end
        queue_op(ACT_PUSH, 2'd1, 32'sh5A5A_A5A5, 1'b0);

        // Alternate push-heavy and pop-heavy stretches so the store keeps
        // running between full and empty.
        for (int k = 0; k < N_RANDOM; k++) begin
            push_bias = ((k / 48) % 2 == 0) ? 20 : 80;
            act = ($urandom_range(0, 99) < push_bias) ? ACT_PUSH : ACT_POP;
            case ($urandom_range(0, 9))
                0: val = MOST_NEG;
                1: val = 32'sh7FFF_FFFF;
                2: val = 32'sd0;
                3: val = -32'sd1;
                default: val = 32'($urandom);
            endcase
            queue_op(act, 2'($urandom_range(0, 3)), val, k == 0 || k == 600);
        end
        n_total = pending.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_done < n_total) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (expected_rsp.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_rsp.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== multi_stack_shared_free_list_top.f =====
rtl/mssfl_pkg.sv
rtl/mssfl_if.sv
rtl/mssfl_ctrl.sv
rtl/mssfl_dp.sv
rtl/multi_stack_shared_free_list_top.sv
sim/tb_top.sv
